// File: hw/rtl/plist_pkg.sv
// Shared definitions for the positional list engine: request and status
// codes, default sizes and the control bundle sent to every list cell.
// No dependencies.
package plist_pkg;

    // Request operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // Field widths fixed by the stream format
    localparam int OP_W     = 2;
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // Default sizes
    localparam int DEPTH_DEF      = 64;
    localparam int ELEM_WIDTH_DEF = 32;

    // Per-request control broadcast to the cell row
    typedef struct packed {
        logic step;   // a request is accepted this cycle
        logic ins;    // successful insert
        logic del;    // successful delete
        logic rd;     // successful read
    } cell_ctrl_t;

endpackage

// File: hw/rtl/positional_list_engine.sv
// Top level of the positional list engine: request checking, the row of
// list cells and the two-stage result path.
// Depends on plist_pkg and plist_cell.
//
// Usage:
//   Requests arrive on the s_ stream (insert, delete or read at a 1-based
//   position); one result per request leaves on the m_ stream with a status,
//   the value read and the list length after the request.
//   Every entry sits in its own cell; an insert or delete moves all cells
//   after the position by one place in the cycle the request is accepted,
//   so the list state is always up to date for the next request.
//   Throughput: one request per cycle while the output is not stalled. The
//   addressed cell's entry is latched with the first result stage, then the
//   cells' read outputs are merged into the output register.
//   Reset (aresetn low at a clock edge) empties the list and drops any
//   result in flight. When m_tready is low the result is held, the middle
//   stage fills, and s_tready drops until the output can move again.
module positional_list_engine #(
    parameter int DEPTH      = plist_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = plist_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tdata: operation[1:0], position[9:2], value[41:10], zero fill [47:42]
    input  logic [plist_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: status[1:0], read_value[33:2], length[40:34], zero fill [47:41]
    output logic [plist_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready
);
    import plist_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    // Request fields
    logic [OP_W-1:0]  req_op;
    logic [POS_W-1:0] req_pos;
    logic [VAL_W-1:0] req_value;

    assign req_op    = s_tdata[OP_W-1:0];
    assign req_pos   = s_tdata[OP_W +: POS_W];
    assign req_value = s_tdata[OP_W+POS_W +: VAL_W];

    // Control state
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                p1_valid_reg, p1_valid_next;
    logic [STATUS_W-1:0] p1_status_reg, p1_status_next;
    logic [LEN_W-1:0]    p1_len_reg, p1_len_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [VAL_W-1:0]    m_rdval_reg, m_rdval_next;
    logic [LEN_W-1:0]    m_len_reg, m_len_next;

    logic accept;
    logic out_free;
    logic p1_free;

    assign out_free = !m_valid_reg || m_tready;
    assign p1_free  = !p1_valid_reg || out_free;
    assign s_tready = p1_free;
    assign accept   = s_tvalid && p1_free;

    // Position checks against the current length
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;
    logic             is_full;
    logic             is_empty;
    logic             pos_zero;
    logic             pos_ins_ok;
    logic             pos_sel_ok;
    logic [STATUS_W-1:0] req_status;
    cell_ctrl_t       ctrl;
    logic [IDX_W-1:0] pos_idx;

    assign pos_c      = CMP_W'(req_pos);
    assign cnt_c      = CMP_W'(count_reg);
    assign is_full    = (cnt_c >= DEPTH_C);
    assign is_empty   = (count_reg == '0);
    assign pos_zero   = (req_pos == '0);
    assign pos_ins_ok = !pos_zero && (pos_c <= cnt_c + CMP_W'(1));
    assign pos_sel_ok = !pos_zero && (pos_c <= cnt_c);
    assign pos_idx    = IDX_W'(pos_c - CMP_W'(1));

    // Request decode
    always_comb begin
        ctrl       = '0;
        ctrl.step  = accept;
        req_status = ST_BADPOS;
        count_next = count_reg;
        unique case (req_op)
            OP_INSERT: begin
                if (is_full) begin
                    req_status = ST_FULL;
                end else if (pos_ins_ok) begin
                    req_status = ST_OK;
                    ctrl.ins   = accept;
                end
            end
            OP_DELETE: begin
                if (is_empty) begin
                    req_status = ST_EMPTY;
                end else if (pos_sel_ok) begin
                    req_status = ST_OK;
                    ctrl.del   = accept;
                end
            end
            OP_READ: begin
                if (is_empty) begin
                    req_status = ST_EMPTY;
                end else if (pos_sel_ok) begin
                    req_status = ST_OK;
                    ctrl.rd    = accept;
                end
            end
            default: begin
                req_status = ST_BADPOS;
            end
        endcase
        if (ctrl.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.del) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Cell row
    logic [ELEM_WIDTH-1:0] ins_value;
    logic [ELEM_WIDTH-1:0] cell_data [DEPTH];
    logic [ELEM_WIDTH-1:0] cell_hit  [DEPTH];

    assign ins_value = ELEM_WIDTH'(req_value);

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [ELEM_WIDTH-1:0] left_d;
        logic [ELEM_WIDTH-1:0] right_d;
        if (gi == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[gi+1];
        end
        plist_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .IDX_W      (IDX_W),
            .INDEX      (gi)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .pos_idx    (pos_idx),
            .ins_value  (ins_value),
            .left_data  (left_d),
            .right_data (right_d),
            .data_out   (cell_data[gi]),
            .hit_out    (cell_hit[gi])
        );
    end

    // Merge of the cells' read outputs; at most one is nonzero
    logic [ELEM_WIDTH-1:0] hit_merge;
    always_comb begin
        hit_merge = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_merge = hit_merge | cell_hit[i];
        end
    end

    // Result pipeline
    always_comb begin
        p1_valid_next  = p1_valid_reg;
        p1_status_next = p1_status_reg;
        p1_len_next    = p1_len_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_rdval_next   = m_rdval_reg;
        m_len_next     = m_len_reg;
        if (out_free) begin
            m_valid_next  = p1_valid_reg;
            m_status_next = p1_status_reg;
            m_rdval_next  = VAL_W'(hit_merge);
            m_len_next    = p1_len_reg;
        end
        if (p1_free) begin
            p1_valid_next  = accept;
            p1_status_next = req_status;
            p1_len_next    = LEN_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg    <= count_next;
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        p1_status_reg <= p1_status_next;
        p1_len_reg    <= p1_len_next;
        m_status_reg  <= m_status_next;
        m_rdval_reg   <= m_rdval_next;
        m_len_reg     <= m_len_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W-STATUS_W-VAL_W-LEN_W)'(0),
                       m_len_reg, m_rdval_reg, m_status_reg};

endmodule

// File: hw/rtl/plist_cell.sv
// One storage cell of the positional list: holds a single entry and moves
// it to or from its neighbors on insert and delete.
// Depends on plist_pkg.
module plist_cell #(
    parameter int ELEM_WIDTH = plist_pkg::ELEM_WIDTH_DEF,
    parameter int IDX_W      = 6,
    parameter int INDEX      = 0
) (
    input  logic                   aclk,
    input  plist_pkg::cell_ctrl_t  ctrl,
    input  logic [IDX_W-1:0]       pos_idx,     // zero-based target position
    input  logic [ELEM_WIDTH-1:0]  ins_value,
    input  logic [ELEM_WIDTH-1:0]  left_data,   // entry of cell INDEX-1
    input  logic [ELEM_WIDTH-1:0]  right_data,  // entry of cell INDEX+1
    output logic [ELEM_WIDTH-1:0]  data_out,
    output logic [ELEM_WIDTH-1:0]  hit_out      // entry if read hits here, else zero
);
    import plist_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [ELEM_WIDTH-1:0] data_reg, data_next;
    logic [ELEM_WIDTH-1:0] hit_reg,  hit_next;
    logic                  at_pos;
    logic                  past_pos;

    assign at_pos   = (MY_IDX == pos_idx);
    assign past_pos = (MY_IDX >  pos_idx);

    // Entry update: insert shifts up from the left, delete pulls from the right
    always_comb begin
        data_next = data_reg;
        if (ctrl.ins) begin
            if (at_pos) begin
                data_next = ins_value;
            end else if (past_pos) begin
                data_next = left_data;
            end
        end else if (ctrl.del) begin
            if (at_pos || past_pos) begin
                data_next = right_data;
            end
        end
    end

    // Read contribution, zero unless this cell is the one addressed
    always_comb begin
        hit_next = hit_reg;
        if (ctrl.step) begin
            hit_next = (ctrl.rd && at_pos) ? data_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        hit_reg  <= hit_next;
    end

    assign data_out = data_reg;
    assign hit_out  = hit_reg;

endmodule

// File: dv/positional_list_engine_test.sv
// Self-checking bench for positional_list_engine: predicts each result with a queue model
// of the list and checks it against the m_ stream, with random stalls on both streams.
// Depends on plist_pkg and the positional_list_engine RTL.
`timescale 1ns / 100ps

module positional_list_engine_test;
    import plist_pkg::*;

    localparam int         LIST_DEPTH  = DEPTH_DEF;
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         MAX_GAP     = 13;
    localparam int         DRAIN_WAIT  = 10;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    rdata;
        logic [LEN_W-1:0]    length;
    } list_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic [IN_TDATA_W-1:0]  s_tdata;   // operation, position, value, zero fill
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // status, read_value, length, zero fill
    logic                   m_tvalid;
    logic                   m_tready;

    // Model of the list contents, front = position 1
    logic [VAL_W-1:0] list_q[$];
    list_result_t     expected_q[$];

    bit src_idle;
    bit sink_idle;
    int hold_len;
    int err_count;
    int result_idx;
    int cycle_count;
    int op_count[4];
    int full_hits;
    int peak_len;

    positional_list_engine i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin : clock_gen
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Apply one request to the list model and return its result
    function automatic list_result_t list_apply(logic [1:0] op, logic [7:0] pos,
                                                logic [VAL_W-1:0] val);
        list_result_t r;
        int n;
        int p;
        n = list_q.size();
        p = int'(pos);
        r.status = ST_OK;
        r.rdata  = '0;
        case (op)
            OP_INSERT: begin
                if (n >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                    full_hits++;
                end else if (p < 1 || p > n + 1) begin
                    r.status = ST_BADPOS;
                end else begin
                    list_q.insert(p - 1, val);
                end
            end
            OP_DELETE: begin
                if (n == 0) r.status = ST_EMPTY;
                else if (p < 1 || p > n) r.status = ST_BADPOS;
                else list_q.delete(p - 1);
            end
            OP_READ: begin
                if (n == 0) r.status = ST_EMPTY;
                else if (p < 1 || p > n) r.status = ST_BADPOS;
                else r.rdata = list_q[p - 1];
            end
            default: r.status = ST_BADPOS;
        endcase
        r.length = LEN_W'(list_q.size());
        if (list_q.size() > peak_len) peak_len = list_q.size();
        op_count[op]++;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch on result %0d: %s", $realtime, result_idx, msg);
        err_count++;
    endtask

    // Send one request; valid stays high into the next call when no gap is drawn
    task automatic send_request(input logic [1:0] op, input logic [7:0] pos,
                                input logic [VAL_W-1:0] val);
        int gap;
        gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= IN_TDATA_W'({$urandom, $urandom});
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {{(IN_TDATA_W - OP_W - POS_W - VAL_W){1'b0}}, val, pos, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_q.push_back(list_apply(op, pos, val));
    endtask

    task automatic stop_requests();
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Edges of the fields, the empty/bad-position ordering and the unused opcode
    task automatic test_directed_cases();
        send_request(OP_READ,   8'd1,   32'h0);
        send_request(OP_DELETE, 8'd1,   32'h0);
        send_request(OP_DELETE, 8'd0,   32'h0);
        send_request(OP_INSERT, 8'd0,   32'h1234_5678);
        send_request(OP_INSERT, 8'd2,   32'h1234_5678);
        send_request(OP_INSERT, 8'd1,   32'h0000_0000);
        send_request(OP_INSERT, 8'd1,   32'hFFFF_FFFF);
        send_request(OP_INSERT, 8'd3,   32'hA5A5_5A5A);
        send_request(OP_INSERT, 8'd255, 32'h5A5A_A5A5);
        send_request(OP_READ,   8'd1,   32'hDEAD_BEEF);
        send_request(OP_READ,   8'd2,   32'h0);
        send_request(OP_READ,   8'd3,   32'h0);
        send_request(OP_READ,   8'd0,   32'h0);
        send_request(OP_READ,   8'd4,   32'h0);
        send_request(OP_READ,   8'd255, 32'h0);
        send_request(OP_DELETE, 8'd0,   32'h0);
        send_request(OP_DELETE, 8'd4,   32'h0);
        send_request(OP_UNUSED, 8'd1,   32'hFFFF_FFFF);
        send_request(OP_UNUSED, 8'd255, 32'h0);
        send_request(OP_DELETE, 8'd2,   32'h0);
        send_request(OP_READ,   8'd2,   32'h0);
        send_request(OP_DELETE, 8'd2,   32'h0);
        send_request(OP_DELETE, 8'd1,   32'h0);
        send_request(OP_READ,   8'd1,   32'h0);
    endtask

    // Mixed traffic that sweeps the length between empty and full
    task automatic test_random_mix(input int n_items, input bit vary_idle);
        int k;
        int n;
        int roll;
        bit grow;
        logic [1:0] op;
        logic [7:0] pos;
        grow = 1'b1;
        for (k = 0; k < n_items; k++) begin
            n = list_q.size();
            if (vary_idle && (k % 200) == 0) begin
                src_idle  = $urandom_range(0, 3) != 0;
                sink_idle = $urandom_range(0, 3) != 0;
            end
            if (n == LIST_DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
            else if (n == 0 && $urandom_range(0, 2) == 0) grow = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                // noise: any opcode, any position
                op  = 2'($urandom_range(0, 3));
                pos = 8'($urandom_range(0, 255));
            end else begin
                roll = $urandom_range(0, 99);
                if (grow) op = (roll < 65) ? OP_INSERT : (roll < 85) ? OP_DELETE : OP_READ;
                else      op = (roll < 20) ? OP_INSERT : (roll < 80) ? OP_DELETE : OP_READ;
                if (op == OP_INSERT) begin
                    case ($urandom_range(0, 7))
                        0:       pos = 8'd1;
                        1:       pos = 8'(n + 1);
                        default: pos = 8'($urandom_range(1, n + 1));
                    endcase
                end else if (n == 0) begin
                    pos = 8'($urandom_range(0, 255));
                end else begin
                    case ($urandom_range(0, 7))
                        0:       pos = 8'd1;
                        1:       pos = 8'(n);
                        default: pos = 8'($urandom_range(1, n));
                    endcase
                end
            end
            send_request(op, pos, pick_value());
        end
    endtask

    // No idling on either stream
    task automatic test_back_to_back();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        test_random_mix(60, 1'b0);
    endtask

    // Long receiver hold-off while inserts keep coming: input must stall, list fills up
    task automatic test_output_stall();
        int k;
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        hold_len  = 300;
        for (k = 0; k < 80; k++)
            send_request(OP_INSERT, 8'($urandom_range(1, list_q.size() + 1)), pick_value());
        send_request(OP_READ, 8'(LIST_DEPTH), 32'h0);
        send_request(OP_READ, 8'(LIST_DEPTH + 1), 32'h0);
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    // Result sink: random stalls, optional long hold-off, checks each accepted result
    initial begin : result_sink
        int stall;
        list_result_t want;
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_len > 0) begin
                stall    = hold_len;
                hold_len = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("no request pending, tdata %h", m_tdata));
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", m_tdata[1:0], want.status));
                if (m_tdata[33:2] !== want.rdata)
                    report_mismatch($sformatf("read_value %h, want %h", m_tdata[33:2],
                                              want.rdata));
                if (m_tdata[40:34] !== want.length)
                    report_mismatch($sformatf("length %0d, want %0d", m_tdata[40:34],
                                              want.length));
            end
            result_idx++;
        end
    end

    // Watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 expected_q.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin : test_sequence
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        hold_len  = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_back_to_back();
        test_output_stall();
        test_random_mix(1400, 1'b1);
        stop_requests();

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Ran %0d requests: %0d insert, %0d delete, %0d read, %0d unused opcode",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("Peak length %0d of %0d, %0d inserts refused on a full list, %0d errors",
                 peak_len, LIST_DEPTH, full_hits, err_count);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
